// ===== rtl/core/pidip_pkg.sv =====
package pidip_pkg;

  // Field widths
  localparam int MEAS_W   = 16;
  localparam int DRIVE_W  = 32;
  localparam int GAIN_W   = 32;
  localparam int OMAX_W   = 15;
  localparam int LIM_W    = 16;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 32;

  // Fixed point: gains carry 20 fraction bits, drive carries 16
  localparam int QIN_FRAC  = 20;
  localparam int QOUT_SHFT = 4;

  // Internal widths
  localparam int ERR_W   = MEAS_W + 1;     // target - measured
  localparam int DE_W    = ERR_W + 1;      // first difference
  localparam int DD_W    = ERR_W + 2;      // second difference
  localparam int PP_W    = GAIN_W + DE_W;  // kp and ki products
  localparam int PD_W    = GAIN_W + DD_W;  // kd product
  localparam int PSUM_W  = PD_W + 1;       // sum of three products
  localparam int ACC_W   = DRIVE_W + QOUT_SHFT;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KP     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_KI     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_KD     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_OMAX   = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ILIM   = 3'd6;

  // Mode codes
  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  // Reset values
  localparam logic [OMAX_W-1:0] OMAX_RST = 15'd5000;
  localparam logic [LIM_W-1:0]  ILIM_RST = 16'd600;

endpackage

// ===== rtl/core/pid_incremental_positional.sv =====
// Channel  Dir  Handshake                tdata (low bit up)
// in       in   in_tvalid / in_tready    measured[15:0], signed
// out      out  out_tvalid / out_tready  drive[31:0], signed Q16.16
// cfg      in   cfg_valid / cfg_ready    cfg_index[2:0], cfg_data[31:0]
//
// Four stages: error/operand register, product register, product-sum
// register, result register. A word passes through them in that order, and one
// word is taken every cycle while out_tready stays high; the error history in the
// first stage and the accumulate-and-clamp in the last stage are the only
// loops carried from word to word.
// rst_n is synchronous and active low; it clears the pipeline, the controller
// history and the configuration registers.
// Each stage advances when the stage after it is empty or advancing, so
// bubbles fill while out_tready is low and in_tready drops only when all four
// stages hold words.
module pid_incremental_positional (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pidip_pkg::MEAS_W-1:0]    in_tdata,   // measured[15:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pidip_pkg::DRIVE_W-1:0]   out_tdata,  // drive[31:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidip_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [pidip_pkg::CDATA_W-1:0]   cfg_data
);

  localparam int ERR_W  = pidip_pkg::ERR_W;
  localparam int DE_W   = pidip_pkg::DE_W;
  localparam int DD_W   = pidip_pkg::DD_W;
  localparam int PP_W   = pidip_pkg::PP_W;
  localparam int PD_W   = pidip_pkg::PD_W;
  localparam int PSUM_W = pidip_pkg::PSUM_W;
  localparam int ACC_W  = pidip_pkg::ACC_W;
  localparam int SH_W   = PSUM_W - pidip_pkg::QOUT_SHFT;
  localparam int DRV_W  = pidip_pkg::DRIVE_W;
  localparam int INC_W  = PSUM_W + 1;

  // Configuration registers
  logic                                    mode_r;
  logic signed [pidip_pkg::MEAS_W-1:0]     target_r;
  logic signed [pidip_pkg::GAIN_W-1:0]     kp_r;
  logic signed [pidip_pkg::GAIN_W-1:0]     ki_r;
  logic signed [pidip_pkg::GAIN_W-1:0]     kd_r;
  logic        [pidip_pkg::OMAX_W-1:0]     out_max_r;
  logic        [pidip_pkg::LIM_W-1:0]      lim_r;

  // Controller history
  logic signed [ERR_W-1:0] last_err_r;
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [ERR_W-1:0] err_sum_r;
  logic signed [ACC_W-1:0] acc_r;

  // Pipeline valids and payload
  logic a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic a_mode_r, b_mode_r, c_mode_r, out_mode_r;
  logic signed [DE_W-1:0]   a_op_p_r;
  logic signed [DE_W-1:0]   a_op_i_r;
  logic signed [DD_W-1:0]   a_op_d_r;
  logic signed [PP_W-1:0]   b_pp_r;
  logic signed [PP_W-1:0]   b_pi_r;
  logic signed [PD_W-1:0]   b_pd_r;
  logic signed [PSUM_W-1:0] c_sum_r;
  logic        [DRV_W-1:0]  out_data_r;

  // Flow control
  logic out_adv, c_free, b_free, a_free, in_acc, c_go;

  assign out_adv   = !out_vld_r || out_tready;
  assign c_free    = !c_vld_r || out_adv;
  assign b_free    = !b_vld_r || c_free;
  assign a_free    = !a_vld_r || b_free;
  assign in_tready = a_free;
  assign in_acc    = in_tvalid && a_free;
  assign c_go      = c_vld_r && out_adv;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pidip_pkg::MODE_INCR;
      target_r  <= '0;
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      out_max_r <= pidip_pkg::OMAX_RST;
      lim_r     <= pidip_pkg::ILIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidip_pkg::REG_MODE:   mode_r    <= cfg_data[0];
        pidip_pkg::REG_TARGET: target_r  <= cfg_data[pidip_pkg::MEAS_W-1:0];
        pidip_pkg::REG_KP:     kp_r      <= cfg_data[pidip_pkg::GAIN_W-1:0];
        pidip_pkg::REG_KI:     ki_r      <= cfg_data[pidip_pkg::GAIN_W-1:0];
        pidip_pkg::REG_KD:     kd_r      <= cfg_data[pidip_pkg::GAIN_W-1:0];
        pidip_pkg::REG_OMAX:   out_max_r <= cfg_data[pidip_pkg::OMAX_W-1:0];
        pidip_pkg::REG_ILIM:   lim_r     <= cfg_data[pidip_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: error, differences and clamped integral sum
  logic signed [pidip_pkg::MEAS_W-1:0] meas;
  logic signed [ERR_W-1:0]  err;
  logic signed [DE_W-1:0]   de1;
  logic signed [DD_W-1:0]   dd2;
  logic signed [DE_W-1:0]   sum_raw;
  logic signed [DE_W-1:0]   lim_s;
  logic signed [ERR_W-1:0]  sum_cl;

  assign meas    = in_tdata;
  assign err     = ERR_W'(target_r) - ERR_W'(meas);
  assign de1     = DE_W'(err) - DE_W'(last_err_r);
  assign dd2     = DD_W'(err) - (DD_W'(last_err_r) <<< 1) + DD_W'(prev_err_r);
  assign sum_raw = DE_W'(err_sum_r) + DE_W'(err);
  assign lim_s   = signed'(DE_W'(lim_r));

  always_comb begin
    if (sum_raw > lim_s) begin
      sum_cl = ERR_W'(lim_s);
    end else if (sum_raw < -lim_s) begin
      sum_cl = ERR_W'(-lim_s);
    end else begin
      sum_cl = ERR_W'(sum_raw);
    end
  end

  // Update history on accept; load operands whenever stage A is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else if (in_acc) begin
      last_err_r <= err;
      if (mode_r == pidip_pkg::MODE_POS) begin
        err_sum_r <= sum_cl;
      end else begin
        prev_err_r <= last_err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_mode_r <= mode_r;
      if (mode_r == pidip_pkg::MODE_POS) begin
        a_op_p_r <= DE_W'(err);
        a_op_i_r <= DE_W'(sum_cl);
        a_op_d_r <= DD_W'(de1);
      end else begin
        a_op_p_r <= de1;
        a_op_i_r <= DE_W'(err);
        a_op_d_r <= dd2;
      end
    end
  end

  // Stage B: gain products
  logic signed [PP_W-1:0] pp;
  logic signed [PP_W-1:0] pi;
  logic signed [PD_W-1:0] pd;

  assign pp = PP_W'(kp_r) * PP_W'(a_op_p_r);
  assign pi = PP_W'(ki_r) * PP_W'(a_op_i_r);
  assign pd = PD_W'(kd_r) * PD_W'(a_op_d_r);

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_mode_r <= a_mode_r;
      b_pp_r   <= pp;
      b_pi_r   <= pi;
      b_pd_r   <= pd;
    end
  end

  // Stage C: sum of products
  always_ff @(posedge clk) begin
    if (c_free) begin
      c_mode_r <= b_mode_r;
      c_sum_r  <= PSUM_W'(b_pp_r) + PSUM_W'(b_pi_r) + PSUM_W'(b_pd_r);
    end
  end

  // Stage D: accumulate and clamp, or narrow and saturate
  logic signed [INC_W-1:0] inc_sum;
  logic signed [INC_W-1:0] inc_hi;
  logic signed [ACC_W-1:0] inc_acc;
  logic signed [SH_W-1:0]  pos_sh;
  logic                    pos_fits;
  logic        [DRV_W-1:0] pos_drv;
  logic signed [ACC_W-1:0] acc_nxt;
  logic        [DRV_W-1:0] drv_nxt;

  assign inc_sum = INC_W'(acc_r) + INC_W'(c_sum_r);
  assign inc_hi  = signed'(INC_W'({out_max_r, {pidip_pkg::QIN_FRAC{1'b0}}}));

  always_comb begin
    if (inc_sum > inc_hi) begin
      inc_acc = ACC_W'(inc_hi);
    end else if (inc_sum < 0) begin
      inc_acc = '0;
    end else begin
      inc_acc = ACC_W'(inc_sum);
    end
  end

  assign pos_sh   = c_sum_r[PSUM_W-1:pidip_pkg::QOUT_SHFT];
  assign pos_fits = (pos_sh[SH_W-1:DRV_W-1] == '0) || (pos_sh[SH_W-1:DRV_W-1] == '1);

  always_comb begin
    if (pos_fits) begin
      pos_drv = pos_sh[DRV_W-1:0];
    end else if (pos_sh[SH_W-1]) begin
      pos_drv = {1'b1, {(DRV_W-1){1'b0}}};
    end else begin
      pos_drv = {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (c_mode_r == pidip_pkg::MODE_POS) begin
      drv_nxt = pos_drv;
      acc_nxt = {pos_drv, {pidip_pkg::QOUT_SHFT{1'b0}}};
    end else begin
      drv_nxt = inc_acc[ACC_W-1:pidip_pkg::QOUT_SHFT];
      acc_nxt = inc_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (c_go) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_mode_r <= c_mode_r;
      out_data_r <= drv_nxt;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (a_free) a_vld_r <= in_acc;
      if (b_free) b_vld_r <= a_vld_r;
      if (c_free) c_vld_r <= b_vld_r;
      if (out_adv) out_vld_r <= c_vld_r;
    end
  end

  // Incremental results are clamped at zero from below
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_mode_r == pidip_pkg::MODE_INCR) |-> !out_data_r[DRV_W-1])
    else $error("negative drive in incremental mode");

  // Input is held off only when every stage holds a word
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_vld_r && b_vld_r && c_vld_r && out_vld_r))
    else $error("input stalled with a free stage");

  // Reset empties the result register
  assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("result valid after reset");

  // A word in the last stage that cannot leave keeps the pipeline behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready && c_vld_r |=> c_vld_r && $stable(c_sum_r))
    else $error("product sum lost while output stalled");

endmodule

// ===== verif/pid_drive_checker.sv =====
`timescale 1ns / 100ps

module pid_drive_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [pidip_pkg::MEAS_W-1:0]  in_tdata,   // measured[15:0]
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [pidip_pkg::DRIVE_W-1:0] out_tdata,  // drive[31:0]
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pidip_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [pidip_pkg::CDATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import pidip_pkg::*;

  // Mirror of the control registers
  logic                       ctl_mode;
  logic signed [MEAS_W-1:0]   ctl_target;
  logic signed [GAIN_W-1:0]   gain_p;
  logic signed [GAIN_W-1:0]   gain_i;
  logic signed [GAIN_W-1:0]   gain_d;
  logic        [OMAX_W-1:0]   drive_ceiling;
  logic        [LIM_W-1:0]    sum_limit;

  // Controller history
  logic signed [ERR_W-1:0]    err_d1;
  logic signed [ERR_W-1:0]    err_d2;
  logic signed [ERR_W:0]      err_integral;
  logic signed [47:0]         drive_accum;

  logic [DRIVE_W-1:0]         drive_expected[$];

  // Advance the controller by one sample and return the Q16.16 drive
  function automatic logic [DRIVE_W-1:0] next_drive(input logic signed [MEAS_W-1:0] meas);
    longint e, acc, ceil_q20, lim, s, v, d;
    e = longint'(ctl_target) - longint'(meas);
    if (ctl_mode == MODE_INCR) begin
      ceil_q20 = longint'(drive_ceiling) <<< QIN_FRAC;
      acc = longint'(drive_accum)
          + longint'(gain_p) * (e - longint'(err_d1))
          + longint'(gain_i) * e
          + longint'(gain_d) * (e - 2 * longint'(err_d1) + longint'(err_d2));
      if (acc > ceil_q20) acc = ceil_q20;
      if (acc < 0) acc = 0;
      drive_accum = acc[47:0];
      err_d2 = err_d1;
      err_d1 = e[ERR_W-1:0];
      d = acc >>> QOUT_SHFT;
    end else begin
      lim = longint'(sum_limit);
      s = longint'(err_integral) + e;
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      err_integral = s[ERR_W:0];
      v = longint'(gain_p) * e + longint'(gain_i) * s
        + longint'(gain_d) * (e - longint'(err_d1));
      // floor to Q16.16, then saturate to the 32-bit range
      d = v >>> QOUT_SHFT;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      v = d <<< QOUT_SHFT;
      drive_accum = v[47:0];
      err_d1 = e[ERR_W-1:0];
    end
    return d[DRIVE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [DRIVE_W-1:0] got,
                                 input logic [DRIVE_W-1:0] want);
    $display("[%0t] drive mismatch: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ctl_mode      = MODE_INCR;
      ctl_target    = '0;
      gain_p        = '0;
      gain_i        = '0;
      gain_d        = '0;
      drive_ceiling = OMAX_RST;
      sum_limit     = ILIM_RST;
      err_d1        = '0;
      err_d2        = '0;
      err_integral  = '0;
      drive_accum   = '0;
      drive_expected.delete();
      fail_count    = 0;
      checked       = 0;
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   ctl_mode      = cfg_data[0];
          REG_TARGET: ctl_target    = cfg_data[MEAS_W-1:0];
          REG_KP:     gain_p        = cfg_data;
          REG_KI:     gain_i        = cfg_data;
          REG_KD:     gain_d        = cfg_data;
          REG_OMAX:   drive_ceiling = cfg_data[OMAX_W-1:0];
          REG_ILIM:   sum_limit     = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      // Compare each drive word against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, '0);
        end else begin
          logic [DRIVE_W-1:0] want;
          want = drive_expected.pop_front();
          if (out_tdata !== want) report_mismatch("drive", out_tdata, want);
          checked++;
        end
      end
      if (in_tvalid && in_tready) drive_expected.push_back(next_drive(in_tdata));
    end
    pending <= drive_expected.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pidip_pkg::*;

  // Index outside the register map; the block must drop such writes
  localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 400;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [MEAS_W-1:0]    in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DRIVE_W-1:0]   out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index;
  logic [CDATA_W-1:0]   cfg_data;

  int  fail_count;
  int  pending;
  int  checked;
  int  n_items;
  int  n_writes;
  int  n_phases;
  bit  in_rush;
  bit  out_rush;

  pid_incremental_positional dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pid_drive_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hold cfg_valid high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
  endtask

  // Stop feeding and wait until every predicted drive word has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_all(input logic md, input logic [MEAS_W-1:0] tg,
                             input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d, input logic [OMAX_W-1:0] om,
                             input logic [LIM_W-1:0] il);
    settle();
    write_reg(REG_MODE, CDATA_W'(md));
    write_reg(REG_TARGET, {{16{tg[MEAS_W-1]}}, tg});
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_OMAX, CDATA_W'(om));
    write_reg(REG_ILIM, CDATA_W'(il));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid only when a gap is drawn, so valid never toggles within one step
  task automatic send_meas(input logic [MEAS_W-1:0] m);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0;
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endcase
  endfunction

  // Result side: random stall per word, with stretches of no stall
  initial begin
    out_tready <= 1'b0;
    out_rush = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      int gap;
      gap = out_rush ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 24) == 0) out_rush = !out_rush;
    end
  end

  initial begin
    #3000000;
    $display("pid_incremental_positional verification failed");
    $finish;
  end

  initial begin
    int base, cnt, m;
    logic [MEAS_W-1:0] tg;
    logic [OMAX_W-1:0] om;
    logic [LIM_W-1:0]  il;

    n_items = 0;
    n_writes = 0;
    n_phases = 0;
    in_rush = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Incremental form: drive the accumulator into both clamps
    program_all(MODE_INCR, 16'h7FFF, 32'h0010_0000, 32'h0001_0000, 32'hFFF8_0000,
                15'h7FFF, 16'hFFFF);
    send_meas(16'h8000);
    send_meas(16'h8000);
    send_meas(16'h7FFF);
    send_meas(16'h7FFF);
    send_meas(16'h0000);
    send_meas(16'hFFFF);

    // Positional form with extreme gains: saturate the drive both ways
    program_all(MODE_POS, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                15'h7FFF, 16'h0000);
    send_meas(16'h8000);
    send_meas(16'h7FFF);
    send_meas(16'h8000);
    send_meas(16'h0000);

    // Integral sum runs into the upper and then the lower limit
    program_all(MODE_POS, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                15'd5000, 16'd40000);
    send_meas(16'h8000);
    send_meas(16'h8000);
    send_meas(16'h7FFF);
    send_meas(16'h7FFF);
    send_meas(16'h7FFF);

    // Ignored index, then mode switch carrying the positional history over
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_MODE, CDATA_W'(MODE_INCR));
    write_reg(REG_OMAX, 32'd0);
    cfg_valid <= 1'b0;
    send_meas(16'd5);
    send_meas(-16'sd5);
    settle();
    write_reg(REG_OMAX, 32'd5000);
    cfg_valid <= 1'b0;
    send_meas(16'd100);
    send_meas(16'd200);
    settle();
    write_reg(REG_MODE, CDATA_W'(MODE_POS));
    cfg_valid <= 1'b0;
    send_meas(16'd7);

    // Random phases: new settings, then samples mostly close to the set point
    base = n_items;
    while (n_items - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: tg = 16'h8000;
        1: tg = 16'h7FFF;
        default: tg = 16'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0: om = '0;
        1: om = 15'h7FFF;
        default: om = 15'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0: il = '0;
        1: il = 16'hFFFF;
        2: il = 16'($urandom());
        default: il = 16'($urandom_range(1, 400));
      endcase
      program_all(1'($urandom_range(0, 1)), tg, draw_gain(), draw_gain(), draw_gain(), om, il);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
      end
      n_phases++;
      in_rush = ($urandom_range(0, 3) == 0);
      cnt = $urandom_range(8, 40);
      repeat (cnt) begin
        if ($urandom_range(0, 4) == 0) begin
          send_meas(16'($urandom()));
        end else begin
          m = int'($signed(tg)) + int'($urandom_range(0, 600)) - 300;
          if (m > 32767) m = 32767;
          if (m < -32768) m = -32768;
          send_meas(16'(m));
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d samples over %0d random setting phases and %0d register writes,",
             n_items, n_phases, n_writes);
    $display("with %0d drive words compared in both controller forms.", checked);
    if (fail_count == 0) begin
      $display("pid_incremental_positional verification clean");
    end else begin
      $display("pid_incremental_positional verification failed");
    end
    $finish;
  end

endmodule
